/* sv/rcn_pkg.sv */
package rcn_pkg;

	localparam int RADIX_W = 30;
	localparam int LIMB_W = 32;
	localparam int DVD_W = LIMB_W + 1;
	localparam int LEN_W = 13;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10000);
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_PUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DVD_W-1:0] quotient;
		logic [RADIX_W-1:0] remainder;
	} div_rsp_t;

endpackage

/* sv/rcn_limb_if.sv */
interface rcn_limb_if;
	logic valid;
	logic ready;
	logic [rcn_pkg::LIMB_W-1:0] limb_value;
	logic is_last;

	modport source (output valid, output limb_value, output is_last, input ready);
	modport sink (input valid, input limb_value, input is_last, output ready);
endinterface

/* sv/rcn_digit_if.sv */
interface rcn_digit_if;
	logic valid;
	logic ready;
	logic [rcn_pkg::RADIX_W-1:0] digit;
	logic end_of_number;
	logic [rcn_pkg::LEN_W-1:0] sig_length;

	modport source (output valid, output digit, output end_of_number, output sig_length,
		input ready);
	modport sink (input valid, input digit, input end_of_number, input sig_length,
		output ready);
endinterface

/* sv/rcn_divider.sv */
module rcn_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  rcn_pkg::div_req_t req,
	output rcn_pkg::div_rsp_t rsp
);

	logic [rcn_pkg::DVD_W-1:0] dvd_q;
	logic [rcn_pkg::RADIX_W-1:0] rem_q;
	logic [rcn_pkg::RADIX_W-1:0] divisor_q;
	logic [rcn_pkg::STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;

	logic [rcn_pkg::RADIX_W:0] shifted;
	logic [rcn_pkg::RADIX_W+1:0] diff;
	logic ge;
	logic [rcn_pkg::RADIX_W-1:0] rem_next;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, dvd_q[rcn_pkg::DVD_W-1]};
		diff = {1'b0, shifted} - {2'b00, divisor_q};
		ge = ~diff[rcn_pkg::RADIX_W+1];
		rem_next = ge ? diff[rcn_pkg::RADIX_W-1:0] : shifted[rcn_pkg::RADIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == rcn_pkg::STEP_W'(rcn_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rcn_pkg::DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

/* sv/radix_carry_normalizer_unit.sv */
// Carry normalizer for big integers held as raw limbs, least significant first.
// Limbs arrive as beats on the limbs channel (limb_value, is_last). Each limb is
// added to the running carry and divided by the radix; the remainder leaves as
// one digit beat on the digits channel and the quotient becomes the new carry.
// After the beat marked is_last, any leftover carry is flushed as more digits.
// The final digit beat of a number has end_of_number set and carries the
// significant length in sig_length; all counters then clear for the next number.
// The radix is written through cfg_we/cfg_wdata; the user must do so only while the
// block is idle, which the block itself does not enforce; values below two act as two.
// One radix-2 restoring divider is shared for every digit and needs 33 steps.
// A limb is accepted in S_IDLE, divided in S_DIV and its digit loaded into the
// output register in S_PUT; the block returns to S_IDLE before it takes a new
// limb. Each flushed carry digit runs another division through S_DIV and S_PUT.
// While a digit waits in the output register the divider keeps working; the
// block only waits when a new digit is ready and the receiver still stalls.
// Reset clears the sequencer, the carry and counters, empties the output
// register and sets the radix to 10000.
module radix_carry_normalizer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	rcn_limb_if.sink                    limbs,
	rcn_digit_if.source                 digits,
	input  logic                        cfg_we,
	input  logic [rcn_pkg::RADIX_W-1:0] cfg_wdata
);

	// Configuration register.
	logic [rcn_pkg::RADIX_W-1:0] radix_q;
	logic [rcn_pkg::RADIX_W-1:0] radix_eff;

	// Number state carried from limb to limb.
	logic [rcn_pkg::LIMB_W-1:0] carry_q;
	logic [rcn_pkg::LEN_W-1:0] count_q;
	logic [rcn_pkg::LEN_W-1:0] top_q;
	logic last_q;

	// Output register.
	logic out_valid_q;
	logic [rcn_pkg::RADIX_W-1:0] out_digit_q;
	logic out_end_q;
	logic [rcn_pkg::LEN_W-1:0] out_len_q;

	rcn_pkg::state_t state_q, state_d;
	rcn_pkg::div_req_t div_req;
	rcn_pkg::div_rsp_t div_rsp;

	logic in_ready;
	logic out_load;
	logic out_free;
	logic finish;
	logic [rcn_pkg::LIMB_W-1:0] quot;
	logic [rcn_pkg::LEN_W-1:0] cnt_bump;
	logic [rcn_pkg::LEN_W-1:0] top_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rcn_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	assign radix_eff = (radix_q < rcn_pkg::RADIX_MIN) ? rcn_pkg::RADIX_MIN : radix_q;

	rcn_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The quotient of a 33-bit sum by a radix of at least two fits in 32 bits.
	assign quot = div_rsp.quotient[rcn_pkg::LIMB_W-1:0];

	// Digit counters saturate at the top of their 13-bit range.
	assign cnt_bump = (count_q == rcn_pkg::LEN_MAX) ? count_q : count_q + 1'b1;
	assign top_next = (div_rsp.remainder != '0) ? cnt_bump : top_q;

	// The number ends once the last limb has been taken and no carry remains.
	// When carry digits were flushed, the top one is nonzero, so the highest
	// nonzero position equals the digit count and serves both cases.
	assign finish = last_q && (quot == '0);

	assign out_free = !out_valid_q || digits.ready;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = {1'b0, quot};
		div_req.divisor = radix_eff;
		case (state_q)
			rcn_pkg::S_IDLE: begin
				in_ready = 1'b1;
				div_req.dividend = {1'b0, limbs.limb_value} + {1'b0, carry_q};
				if (limbs.valid) begin
					div_req.start = 1'b1;
					state_d = rcn_pkg::S_DIV;
				end
			end
			rcn_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = rcn_pkg::S_PUT;
				end
			end
			rcn_pkg::S_PUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (last_q && !finish) begin
						// Flush the next carry digit.
						div_req.start = 1'b1;
						state_d = rcn_pkg::S_DIV;
					end else begin
						state_d = rcn_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = rcn_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcn_pkg::S_IDLE;
			carry_q <= '0;
			count_q <= '0;
			top_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_ready && limbs.valid) begin
				last_q <= limbs.is_last;
			end
			if (out_load) begin
				carry_q <= finish ? '0 : quot;
				count_q <= finish ? '0 : cnt_bump;
				top_q <= finish ? '0 : top_next;
				out_valid_q <= 1'b1;
			end else if (digits.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_digit_q <= div_rsp.remainder;
			out_end_q <= finish;
			out_len_q <= finish ? top_next : '0;
		end
	end

	assign limbs.ready = in_ready;
	assign digits.valid = out_valid_q;
	assign digits.digit = out_digit_q;
	assign digits.end_of_number = out_end_q;
	assign digits.sig_length = out_len_q;

	// A digit taken from the divider is always below the radix in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (div_rsp.remainder < radix_eff))
	else $error("normalized digit not below radix");

	// Ending a number leaves no carry and no counted digits behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && finish) |=> (carry_q == '0 && count_q == '0 && top_q == '0))
	else $error("number state not cleared after final digit");

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == rcn_pkg::S_DIV))
	else $error("divider finished outside of a division");

	// A new division never starts while the divider is still stepping.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
	else $error("divider restarted while busy");

endmodule
